### hdl/btpc_pkg.sv
`default_nettype none
package btpc_pkg;
   localparam int unsigned WordWidth = 32;
   localparam int unsigned RawWidth  = 20;
   localparam int unsigned DivSteps  = 32;

   typedef enum logic [1:0] {
      CSR_CAL_TEMP    = 2'd0,
      CSR_CAL_PRESS_A = 2'd1,
      CSR_CAL_PRESS_B = 2'd2,
      CSR_CAL_PRESS_P9 = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [31:0] t1;
      logic [31:0] t2;
      logic [31:0] t3;
      logic [31:0] p1;
      logic [31:0] p2;
      logic [31:0] p3;
      logic [31:0] p4;
      logic [31:0] p5;
      logic [31:0] p6;
      logic [31:0] p7;
      logic [31:0] p8;
      logic [31:0] p9;
   } cal_type;

   // Wrapping 32-bit product.
   function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
      logic [63:0] prod;
      prod = a * b;
      return prod[31:0];
   endfunction

   function automatic logic [31:0] asr(input logic [31:0] v, input int unsigned s);
      return 32'($signed(v) >>> s);
   endfunction

   function automatic logic [31:0] sext16(input logic [15:0] w);
      return {{16{w[15]}}, w};
   endfunction
endpackage
`default_nettype wire

### hdl/btpc_divider.sv
`default_nettype none
// Pipelined restoring divider: one quotient bit per stage.
module btpc_divider
   import btpc_pkg::*;
#(
   parameter int unsigned TagWidth = 1
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   input  wire logic [31:0]         in_num,
   input  wire logic [31:0]         in_den,
   input  wire logic [TagWidth-1:0] in_tag,
   output logic                     out_valid,
   output logic [31:0]              out_quo,
   output logic [TagWidth-1:0]      out_tag
);
   logic [DivSteps-1:0]  vld_ff;
   logic [31:0]          num_ff [DivSteps];
   logic [31:0]          rem_ff [DivSteps-1];
   logic [31:0]          den_ff [DivSteps-1];
   logic [TagWidth-1:0]  tag_ff [DivSteps];
   logic [63:0]          step_in [DivSteps];

   // One restoring step: the next dividend bit moves into the remainder and
   // the divisor is taken off where it fits. Gives {remainder, shifted word}.
   function automatic logic [63:0] div_step(input logic [31:0] rem,
                                            input logic [31:0] num,
                                            input logic [31:0] den);
      logic [32:0] trial;
      logic [32:0] diff;
      trial = {rem, num[31]};
      diff  = trial - {1'b0, den};
      if (trial >= {1'b0, den}) return {diff[31:0], num[30:0], 1'b1};
      return {trial[31:0], num[30:0], 1'b0};
   endfunction

   always_comb begin
      step_in[0] = div_step(32'd0, in_num, in_den);
      for (int i = 1; i < DivSteps; i++)
         step_in[i] = div_step(rem_ff[i-1], num_ff[i-1], den_ff[i-1]);
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else       vld_ff <= {vld_ff[DivSteps-2:0], in_valid};
      for (int i = 0; i < DivSteps; i++)
         num_ff[i] <= step_in[i][31:0];
      for (int i = 0; i < DivSteps - 1; i++)
         rem_ff[i] <= step_in[i][63:32];
      den_ff[0] <= in_den;
      for (int i = 1; i < DivSteps - 1; i++)
         den_ff[i] <= den_ff[i-1];
      tag_ff[0] <= in_tag;
      for (int i = 1; i < DivSteps; i++)
         tag_ff[i] <= tag_ff[i-1];
   end

   assign out_valid = vld_ff[DivSteps-1];
   assign out_quo   = num_ff[DivSteps-1];
   assign out_tag   = tag_ff[DivSteps-1];
endmodule
`default_nettype wire

### hdl/btpc_front.sv
`default_nettype none
// Temperature and pressure terms, registered after every product.
module btpc_front
   import btpc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cal_type     cal,
   input  wire logic        in_valid,
   input  wire logic [19:0] in_adc_t,
   input  wire logic [19:0] in_adc_p,
   output logic             out_valid,
   output logic [31:0]      out_temp,
   output logic [31:0]      out_num,
   output logic [31:0]      out_den
);
   logic [5:0]  v_ff;
   // stage 1
   logic [31:0] s1_m1_ff, s1_dd_ff;
   logic [19:0] s1_p_ff;
   // stage 2
   logic [31:0] s2_a_ff, s2_m2_ff;
   logic [19:0] s2_p_ff;
   // stage 3
   logic [31:0] s3_fine_ff, s3_f5_ff;
   logic [19:0] s3_p_ff;
   // stage 4
   logic [31:0] s4_temp_ff, s4_sq_ff, s4_ap5_ff, s4_p2a_ff;
   logic [19:0] s4_p_ff;
   // stage 5
   logic [31:0] s5_temp_ff, s5_b1_ff, s5_p3sq_ff, s5_p2a_ff, s5_ap5_ff;
   logic [19:0] s5_p_ff;
   // stage 6
   logic [31:0] s6_temp_ff, s6_num_ff, s6_den_ff;

   logic [31:0] d_in, a_in, sum_a, x_in, b_in;
   always_comb begin
      d_in  = {12'd0, in_adc_t} >> 4;
      d_in  = d_in - cal.t1;
      a_in  = asr(s3_fine_ff, 1) - 32'd64000;
      sum_a = asr(asr(s5_p3sq_ff, 3) + asr(s5_p2a_ff, 1), 18);
      x_in  = 32'd32768 + sum_a;
      b_in  = asr(s5_b1_ff + (s5_ap5_ff << 1), 2) + (cal.p4 << 16);
      b_in  = (32'd1048576 - {12'd0, s5_p_ff}) - asr(b_in, 12);
   end

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else       v_ff <= {v_ff[4:0], in_valid};
      s1_m1_ff <= mul32(({12'd0, in_adc_t} >> 3) - (cal.t1 << 1), cal.t2);
      s1_dd_ff <= mul32(d_in, d_in);
      s1_p_ff  <= in_adc_p;
      s2_a_ff  <= asr(s1_m1_ff, 11);
      s2_m2_ff <= mul32(asr(s1_dd_ff, 12), cal.t3);
      s2_p_ff  <= s1_p_ff;
      s3_fine_ff <= s2_a_ff + asr(s2_m2_ff, 14);
      s3_f5_ff   <= mul32(s2_a_ff + asr(s2_m2_ff, 14), 32'd5);
      s3_p_ff    <= s2_p_ff;
      s4_temp_ff <= asr(s3_f5_ff + 32'd128, 8);
      s4_sq_ff   <= mul32(asr(a_in, 2), asr(a_in, 2));
      s4_ap5_ff  <= mul32(a_in, cal.p5);
      s4_p2a_ff  <= mul32(cal.p2, a_in);
      s4_p_ff    <= s3_p_ff;
      s5_temp_ff  <= s4_temp_ff;
      s5_b1_ff    <= mul32(asr(s4_sq_ff, 11), cal.p6);
      s5_p3sq_ff  <= mul32(cal.p3, asr(s4_sq_ff, 13));
      s5_p2a_ff   <= s4_p2a_ff;
      s5_ap5_ff   <= s4_ap5_ff;
      s5_p_ff     <= s4_p_ff;
      s6_temp_ff <= s5_temp_ff;
      s6_den_ff  <= asr(mul32(x_in, cal.p1), 15);
      s6_num_ff  <= mul32(b_in, 32'd3125);
   end

   assign out_valid = v_ff[5];
   assign out_temp  = s6_temp_ff;
   assign out_num   = s6_num_ff;
   assign out_den   = s6_den_ff;
endmodule
`default_nettype wire

### hdl/btpc_back.sv
`default_nettype none
// Final pressure correction after the division.
module btpc_back
   import btpc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cal_type     cal,
   input  wire logic        in_valid,
   input  wire logic [31:0] in_quo,
   input  wire logic        in_wide,
   input  wire logic        in_dz,
   input  wire logic [31:0] in_temp,
   output logic             out_valid,
   output logic [31:0]      out_temp,
   output logic [31:0]      out_press,
   output logic             out_dz
);
   logic [3:0]  v_ff;
   logic [31:0] p1_ff, p2_ff, p3_ff, p4_ff;
   logic [31:0] sq_ff, m9_ff, m8_ff, m8d_ff, fin_ff;
   logic [31:0] t_ff [4];
   logic [3:0]  dz_ff;
   logic [31:0] p_in;

   assign p_in = in_wide ? (in_quo << 1) : in_quo;

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else       v_ff <= {v_ff[2:0], in_valid};
      p1_ff <= p_in;
      sq_ff <= mul32(p_in >> 3, p_in >> 3);
      m8_ff <= mul32(p_in >> 2, cal.p8);
      p2_ff <= p1_ff;
      m9_ff <= mul32(cal.p9, sq_ff >> 13);
      m8d_ff <= m8_ff;
      p3_ff <= p2_ff;
      fin_ff <= asr(asr(m9_ff, 12) + asr(m8d_ff, 13) + cal.p7, 4);
      p4_ff <= p3_ff + fin_ff;
      t_ff[0] <= in_temp;
      t_ff[1] <= t_ff[0];
      t_ff[2] <= t_ff[1];
      t_ff[3] <= t_ff[2];
      dz_ff <= {dz_ff[2:0], in_dz};
   end

   assign out_valid = v_ff[3];
   assign out_temp  = t_ff[3];
   assign out_dz    = dz_ff[3];
   assign out_press = dz_ff[3] ? 32'd0 : p4_ff;
endmodule
`default_nettype wire

### hdl/baro_temp_pressure_compensation.sv
`default_nettype none
// Barometric temperature and pressure compensation engine.
// Usage: write the calibration words through the csr_ port (index 0 to 3)
// while the block is idle. Raise start for one cycle with a pair of raw
// 20-bit readings; a transfer happens whenever start is high, as busy is
// always low: the pipeline takes a new pair in every cycle.
// Each pair gives exactly one result, shown for one cycle with rsp_valid
// high. On its way it passes six stages of temperature and divisor
// terms, a 32-stage bit-per-stage divider and four correction stages,
// 42 registers in all; throughput is one item per cycle.
// A zero divisor yields pressure 0 with rsp_divide_by_zero set.
// Synchronous reset clears the valid bits and the calibration words to 0.
// The receiver cannot stall, so results never wait.
module baro_temp_pressure_compensation
   import btpc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [19:0] req_raw_temperature,
   input  wire logic [19:0] req_raw_pressure,
   output logic             rsp_valid,
   output logic signed [31:0] rsp_temperature_centi,
   output logic [31:0]      rsp_pressure_pa,
   output logic             rsp_divide_by_zero,
   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [63:0] csr_data
);
   logic [47:0] cal_temp_ff;
   logic [63:0] cal_press_a_ff, cal_press_b_ff;
   logic [15:0] cal_press_p9_ff;
   cal_type     cal;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_temp_ff     <= '0;
         cal_press_a_ff  <= '0;
         cal_press_b_ff  <= '0;
         cal_press_p9_ff <= '0;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_CAL_TEMP:     cal_temp_ff     <= csr_data[47:0];
            CSR_CAL_PRESS_A:  cal_press_a_ff  <= csr_data;
            CSR_CAL_PRESS_B:  cal_press_b_ff  <= csr_data;
            CSR_CAL_PRESS_P9: cal_press_p9_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cal.t1 = {16'd0, cal_temp_ff[15:0]};
      cal.t2 = sext16(cal_temp_ff[31:16]);
      cal.t3 = sext16(cal_temp_ff[47:32]);
      cal.p1 = {16'd0, cal_press_a_ff[15:0]};
      cal.p2 = sext16(cal_press_a_ff[31:16]);
      cal.p3 = sext16(cal_press_a_ff[47:32]);
      cal.p4 = sext16(cal_press_a_ff[63:48]);
      cal.p5 = sext16(cal_press_b_ff[15:0]);
      cal.p6 = sext16(cal_press_b_ff[31:16]);
      cal.p7 = sext16(cal_press_b_ff[47:32]);
      cal.p8 = sext16(cal_press_b_ff[63:48]);
      cal.p9 = sext16(cal_press_p9_ff);
   end

   assign busy = 1'b0;

   logic        f_valid;
   logic [31:0] f_temp, f_num, f_den;

   btpc_front u_front (
      .clock, .reset, .cal,
      .in_valid (start & ~busy),
      .in_adc_t (req_raw_temperature),
      .in_adc_p (req_raw_pressure),
      .out_valid(f_valid), .out_temp(f_temp), .out_num(f_num), .out_den(f_den)
   );

   // Numerator pre-scaling: below 2^31 the value is doubled before division,
   // otherwise the quotient is doubled afterwards. Zero divisor is tagged.
   localparam int unsigned TagW = 34;
   logic        wide;
   logic [31:0] div_num, d_quo;
   logic [TagW-1:0] d_tag;
   logic        d_valid;
   assign wide    = f_num[31];
   assign div_num = wide ? f_num : (f_num << 1);

   btpc_divider #(.TagWidth(TagW)) u_div (
      .clock, .reset,
      .in_valid (f_valid),
      .in_num   (div_num),
      .in_den   (f_den),
      .in_tag   ({wide, (f_den == 32'd0), f_temp}),
      .out_valid(d_valid), .out_quo(d_quo), .out_tag(d_tag)
   );

   logic [31:0] b_temp;
   btpc_back u_back (
      .clock, .reset, .cal,
      .in_valid (d_valid),
      .in_quo   (d_quo),
      .in_wide  (d_tag[33]),
      .in_dz    (d_tag[32]),
      .in_temp  (d_tag[31:0]),
      .out_valid(rsp_valid),
      .out_temp (b_temp),
      .out_press(rsp_pressure_pa),
      .out_dz   (rsp_divide_by_zero)
   );
   assign rsp_temperature_centi = $signed(b_temp);

`ifndef ASSERT_OFF
   a_never_busy: assert property (@(posedge clock) busy == 1'b0)
      else $error("busy raised");
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divide_by_zero |-> rsp_pressure_pa == 32'd0)
      else $error("zero divisor with nonzero pressure");
   a_reset_quiet: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result straight after reset");
`endif
endmodule
`default_nettype wire

### tb/tb_top.sv
`default_nettype none
// Self-checking testbench for the barometric compensation engine.
module tb_top
   import btpc_pkg::*;
();

   localparam int unsigned IdleLimit   = 2000;
   localparam int unsigned DrainCycles = 60;
   localparam int unsigned PhaseItems  = 160;
   localparam int unsigned PhaseCount  = 8;

   // One compensated reading, as the block reports it.
   typedef struct {
      logic [31:0] temperature;
      logic [31:0] pressure;
      logic        div_zero;
   } reading_type;

   // One row of the directed stimulus. Rows with known_result set carry a
   // result that can be read straight off the compensation formulae.
   typedef struct {
      logic [19:0] raw_t;
      logic [19:0] raw_p;
      bit          known_result;
      reading_type result;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [19:0] req_raw_temperature;
   logic [19:0] req_raw_pressure;
   logic        rsp_valid;
   logic signed [31:0] rsp_temperature_centi;
   logic [31:0] rsp_pressure_pa;
   logic        rsp_divide_by_zero;
   logic        csr_write;
   logic [1:0]  csr_index;
   logic [63:0] csr_data;

   // The testbench's own copy of the calibration registers.
   logic [47:0] cal_temp_copy;
   logic [63:0] cal_press_a_copy;
   logic [63:0] cal_press_b_copy;
   logic [15:0] cal_p9_copy;

   reading_type pending_readings[$];
   int unsigned mismatch_count;
   int unsigned idle_cycles;
   bit          transfer_seen;

   baro_temp_pressure_compensation i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_raw_temperature   (req_raw_temperature),
      .req_raw_pressure      (req_raw_pressure),
      .rsp_valid             (rsp_valid),
      .rsp_temperature_centi (rsp_temperature_centi),
      .rsp_pressure_pa       (rsp_pressure_pa),
      .rsp_divide_by_zero    (rsp_divide_by_zero),
      .csr_write             (csr_write),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Sign-filling right shift of a 32-bit pattern.
   function automatic logic [31:0] shift_signed(input logic [31:0] v, input int unsigned s);
      logic signed [31:0] sv;
      sv = v;
      return sv >>> s;
   endfunction

   function automatic logic [31:0] widen16(input logic [15:0] w);
      return {{16{w[15]}}, w};
   endfunction

   // Integer compensation with every step wrapping at 32 bits. The fine
   // temperature from the first half feeds the pressure half.
   function automatic reading_type compensate(input logic [19:0] raw_t,
                                              input logic [19:0] raw_p);
      reading_type r;
      logic [31:0] adc_t, adc_p, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic [31:0] a, b, d, fine, sq, p, prod, q;
      adc_t = {12'd0, raw_t};
      adc_p = {12'd0, raw_p};
      t1 = {16'd0, cal_temp_copy[15:0]};
      t2 = widen16(cal_temp_copy[31:16]);
      t3 = widen16(cal_temp_copy[47:32]);
      p1 = {16'd0, cal_press_a_copy[15:0]};
      p2 = widen16(cal_press_a_copy[31:16]);
      p3 = widen16(cal_press_a_copy[47:32]);
      p4 = widen16(cal_press_a_copy[63:48]);
      p5 = widen16(cal_press_b_copy[15:0]);
      p6 = widen16(cal_press_b_copy[31:16]);
      p7 = widen16(cal_press_b_copy[47:32]);
      p8 = widen16(cal_press_b_copy[63:48]);
      p9 = widen16(cal_p9_copy);

      prod = ((adc_t >> 3) - (t1 << 1)) * t2;
      a = shift_signed(prod, 11);
      d = (adc_t >> 4) - t1;
      prod = d * d;
      prod = shift_signed(prod, 12) * t3;
      b = shift_signed(prod, 14);
      fine = a + b;
      prod = fine * 32'd5 + 32'd128;
      r.temperature = shift_signed(prod, 8);

      a = shift_signed(fine, 1) - 32'd64000;
      sq = shift_signed(a, 2) * shift_signed(a, 2);
      b = shift_signed(sq, 11) * p6;
      prod = a * p5;
      b = b + (prod << 1);
      b = shift_signed(b, 2) + (p4 << 16);
      prod = p3 * shift_signed(sq, 13);
      q = p2 * a;
      a = shift_signed(shift_signed(prod, 3) + shift_signed(q, 1), 18);
      prod = (32'd32768 + a) * p1;
      a = shift_signed(prod, 15);

      if (a == 32'd0) begin
         r.pressure = 32'd0;
         r.div_zero = 1'b1;
      end else begin
         p = ((32'd1048576 - adc_p) - shift_signed(b, 12)) * 32'd3125;
         if (p < 32'h8000_0000) begin
            q = p << 1;
            p = q / a;
         end else begin
            q = p / a;
            p = q * 32'd2;
         end
         q = (p >> 3) * (p >> 3);
         prod = p9 * (q >> 13);
         a = shift_signed(prod, 12);
         prod = (p >> 2) * p8;
         b = shift_signed(prod, 13);
         r.pressure = p + shift_signed(a + b + p7, 4);
         r.div_zero = 1'b0;
      end
      return r;
   endfunction

   // A register write takes effect at the rising edge; the shadow copy
   // drops the bits above each register's width.
   task automatic write_reg(input csr_index_type idx, input logic [63:0] value);
      @(negedge clock);
      csr_write = 1'b1;
      csr_index = idx;
      csr_data  = value;
      @(negedge clock);
      csr_write = 1'b0;
      case (idx)
         CSR_CAL_TEMP:     cal_temp_copy    = value[47:0];
         CSR_CAL_PRESS_A:  cal_press_a_copy = value;
         CSR_CAL_PRESS_B:  cal_press_b_copy = value;
         CSR_CAL_PRESS_P9: cal_p9_copy      = value[15:0];
         default: ;
      endcase
   endtask

   task automatic write_all(input logic [47:0] ct, input logic [63:0] pa,
                            input logic [63:0] pb, input logic [15:0] p9);
      // Noise above each register's width must be ignored by the block.
      write_reg(CSR_CAL_TEMP, {16'($urandom()), ct});
      write_reg(CSR_CAL_PRESS_A, pa);
      write_reg(CSR_CAL_PRESS_B, pb);
      write_reg(CSR_CAL_PRESS_P9, {32'($urandom()), 16'($urandom()), p9});
   endtask

   // Calibration is only changed once every result is in. Nothing is
   // outstanding inside the pipeline then, but a short pause is kept anyway.
   task automatic wait_idle;
      start = 1'b0;
      wait (pending_readings.size() == 0);
      repeat (DrainCycles) @(negedge clock);
   endtask

   // Offer one reading pair, optionally after a random gap, and record the
   // expected result at the edge that makes the transfer.
   task automatic send_pair(input logic [19:0] raw_t, input logic [19:0] raw_p,
                            input bit with_gaps, input bit known,
                            input reading_type known_result);
      int unsigned gap;
      bit taken;
      gap = with_gaps ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      start = 1'b1;
      req_raw_temperature = raw_t;
      req_raw_pressure    = raw_p;
      taken = 1'b0;
      while (!taken) begin
         @(posedge clock);
         if (!busy) begin
            taken = 1'b1;
            pending_readings.push_back(known ? known_result : compensate(raw_t, raw_p));
         end
      end
      @(negedge clock);
   endtask

   function automatic logic [19:0] draw_raw;
      // Mostly readings from a plausible window, the rest anywhere.
      if ($urandom_range(0, 9) < 7) return 20'($urandom_range(300000, 650000));
      return 20'($urandom());
   endfunction

   // Results are compared against the oldest expectation as they appear.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_readings.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result: temp %0d press %0d dz %0b",
                        rsp_temperature_centi, rsp_pressure_pa, rsp_divide_by_zero);
         end else begin
            reading_type want;
            want = pending_readings.pop_front();
            if (rsp_temperature_centi !== want.temperature ||
                rsp_pressure_pa !== want.pressure ||
                rsp_divide_by_zero !== want.div_zero) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("result differs: temp %0d/%0d press %0d/%0d dz %0b/%0b (exp/got)",
                           $signed(want.temperature), rsp_temperature_centi,
                           want.pressure, rsp_pressure_pa,
                           want.div_zero, rsp_divide_by_zero);
            end
         end
      end
   end

   // Watchdog: a long stretch without any transfer on either side means
   // the block has hung.
   always @(posedge clock) begin
      transfer_seen = (start && !busy) || rsp_valid;
      if (reset || transfer_seen) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IdleLimit) begin
            $display("baro_temp_pressure_compensation: mismatch");
            $finish;
         end
      end
   end

   initial begin
      stim_row_type zero_cal_rows[5];
      stim_row_type typical_rows[9];
      reading_type  zero_result;
      reading_type  none;
      logic [47:0]  ct;
      logic [63:0]  pa, pb;
      logic [15:0]  p9;
      bit           bursty;

      start = 1'b0;
      req_raw_temperature = '0;
      req_raw_pressure = '0;
      csr_write = 1'b0;
      csr_index = CSR_CAL_TEMP;
      csr_data = '0;
      mismatch_count = 0;
      idle_cycles = 0;
      cal_temp_copy = '0;
      cal_press_a_copy = '0;
      cal_press_b_copy = '0;
      cal_p9_copy = '0;
      none = '{32'd0, 32'd0, 1'b0};

      // With every calibration word at zero the fine temperature is zero,
      // the temperature is zero and the pressure divisor vanishes.
      zero_result = '{32'd0, 32'd0, 1'b1};
      zero_cal_rows = '{
         '{20'h00000, 20'h00000, 1'b1, zero_result},
         '{20'hFFFFF, 20'hFFFFF, 1'b1, zero_result},
         '{20'h00000, 20'hFFFFF, 1'b1, zero_result},
         '{20'hFFFFF, 20'h00000, 1'b1, zero_result},
         '{20'h80000, 20'h80000, 1'b1, zero_result}
      };
      typical_rows = '{
         '{20'd519888, 20'd415148, 1'b0, none},
         '{20'h00000, 20'h00000, 1'b0, none},
         '{20'hFFFFF, 20'hFFFFF, 1'b0, none},
         '{20'h00000, 20'hFFFFF, 1'b0, none},
         '{20'hFFFFF, 20'h00000, 1'b0, none},
         '{20'h55555, 20'hAAAAA, 1'b0, none},
         '{20'hAAAAA, 20'h55555, 1'b0, none},
         '{20'd400000, 20'd300000, 1'b0, none},
         '{20'd600000, 20'd600000, 1'b0, none}
      };

      reset = 1'b1;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      foreach (zero_cal_rows[i])
         send_pair(zero_cal_rows[i].raw_t, zero_cal_rows[i].raw_p, 1'b1,
                   zero_cal_rows[i].known_result, zero_cal_rows[i].result);
      wait_idle();

      // A typical factory calibration set.
      write_all({16'hFC18, 16'd26435, 16'd27504},
                {16'd2855, 16'd3024, 16'hD643, 16'd36477},
                {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140}, 16'd6000);
      foreach (typical_rows[i])
         send_pair(typical_rows[i].raw_t, typical_rows[i].raw_p, 1'b1,
                   typical_rows[i].known_result, typical_rows[i].result);

      for (int phase = 0; phase < PhaseCount; phase++) begin
         wait_idle();
         case (phase)
            0: begin
               // All ones: T1 and P1 at their largest, every signed coefficient at -1.
               ct = '1; pa = '1; pb = '1; p9 = '1;
            end
            1: begin
               // P1 zero forces the divisor to vanish for any reading.
               ct = {$urandom(), 16'($urandom())};
               pa = {$urandom(), $urandom()} & ~64'hFFFF;
               pb = {$urandom(), $urandom()};
               p9 = 16'($urandom());
            end
            2, 3: begin
               ct = {$urandom(), 16'($urandom())};
               pa = {$urandom(), $urandom()};
               pb = {$urandom(), $urandom()};
               p9 = 16'($urandom());
            end
            default: begin
               // Near the typical set, with the low bits stirred.
               ct = {16'hFC18, 16'd26435, 16'd27504} ^ 48'($urandom() & 32'h00FF_00FF);
               pa = {16'd2855, 16'd3024, 16'hD643, 16'd36477}
                    ^ {$urandom() & 32'h00FF_00FF, $urandom() & 32'h00FF_00FF};
               pb = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140}
                    ^ {$urandom() & 32'h00FF_00FF, $urandom() & 32'h00FF_00FF};
               p9 = 16'd6000 ^ 16'($urandom_range(0, 255));
            end
         endcase
         write_all(ct, pa, pb, p9);
         // Some phases run back to back so the pipeline is kept full.
         bursty = (phase % 3 == 2);
         for (int n = 0; n < PhaseItems; n++)
            send_pair(draw_raw(), draw_raw(), !bursty, 1'b0, none);
         start = 1'b0;
      end

      wait (pending_readings.size() == 0);
      repeat (DrainCycles) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("baro_temp_pressure_compensation: match");
      end else begin
         $display("baro_temp_pressure_compensation: mismatch");
      end
      $finish;
   end
endmodule
`default_nettype wire
